>>> hdl/slsw_pkg.sv
package slsw_pkg;

  // fixed field widths
  localparam int DIM_W   = 5;
  localparam int LANE_W  = 7;
  localparam int AREA_W  = 2 * DIM_W;
  localparam int COORD_W = 4;
  localparam int LEVEL_W = 8;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 5;

  // register indexes
  localparam logic [2:0] REG_WIDTH  = 3'd0;
  localparam logic [2:0] REG_HEIGHT = 3'd1;
  localparam logic [2:0] REG_LANE   = 3'd2;
  localparam logic [2:0] REG_RED    = 3'd3;
  localparam logic [2:0] REG_GREEN  = 3'd4;
  localparam logic [2:0] REG_BLUE   = 3'd5;
  localparam logic [2:0] REG_WHITE  = 3'd6;

  typedef struct packed {
    logic [DIM_W-1:0]   panel_width;
    logic [DIM_W-1:0]   panel_height;
    logic [LANE_W-1:0]  lane_pixels;
    logic [LEVEL_W-1:0] red_level;
    logic [LEVEL_W-1:0] green_level;
    logic [LEVEL_W-1:0] blue_level;
    logic [LEVEL_W-1:0] white_level;
  } cfg_t;

  typedef struct packed {
    logic start;
    logic restart;
    logic emit;
    logic advance;
  } cmd_t;

  typedef struct packed {
    logic len_zero;
    logic last_pix;
    logic out_free;
  } status_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

endpackage

>>> hdl/slsw_if.sv
interface slsw_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

interface slsw_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] x_coord;
  logic [3:0] y_coord;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic [7:0] white_out;
  logic       frame_last;

  modport source (output valid, output x_coord, output y_coord, output red_out,
                  output green_out, output blue_out, output white_out,
                  output frame_last, input ready);
  modport sink (input valid, input x_coord, input y_coord, input red_out,
                input green_out, input blue_out, input white_out,
                input frame_last, output ready);
endinterface

>>> hdl/slsw_regs.sv
module slsw_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [slsw_pkg::ADDR_W-1:0]  paddr,
  input  logic [slsw_pkg::DATA_W-1:0]  pwdata,
  output logic [slsw_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  output slsw_pkg::cfg_t               cfg
);
  import slsw_pkg::*;

  cfg_t       cfg_r;
  cfg_t       cfg_nxt;
  logic [2:0] idx;
  logic       wr_en;

  assign idx   = paddr[ADDR_W-1:2];
  assign wr_en = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg   = cfg_r;

  // register write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_WIDTH:  cfg_nxt.panel_width  = pwdata[DIM_W-1:0];
        REG_HEIGHT: cfg_nxt.panel_height = pwdata[DIM_W-1:0];
        REG_LANE:   cfg_nxt.lane_pixels  = pwdata[LANE_W-1:0];
        REG_RED:    cfg_nxt.red_level    = pwdata[LEVEL_W-1:0];
        REG_GREEN:  cfg_nxt.green_level  = pwdata[LEVEL_W-1:0];
        REG_BLUE:   cfg_nxt.blue_level   = pwdata[LEVEL_W-1:0];
        REG_WHITE:  cfg_nxt.white_level  = pwdata[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.panel_width  <= DIM_W'(16);
      cfg_r.panel_height <= DIM_W'(16);
      cfg_r.lane_pixels  <= LANE_W'(8);
      cfg_r.red_level    <= '0;
      cfg_r.green_level  <= '0;
      cfg_r.blue_level   <= '0;
      cfg_r.white_level  <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // read back
  always_comb begin
    case (idx)
      REG_WIDTH:  prdata = DATA_W'(cfg_r.panel_width);
      REG_HEIGHT: prdata = DATA_W'(cfg_r.panel_height);
      REG_LANE:   prdata = DATA_W'(cfg_r.lane_pixels);
      REG_RED:    prdata = DATA_W'(cfg_r.red_level);
      REG_GREEN:  prdata = DATA_W'(cfg_r.green_level);
      REG_BLUE:   prdata = DATA_W'(cfg_r.blue_level);
      REG_WHITE:  prdata = DATA_W'(cfg_r.white_level);
      default:    prdata = '0;
    endcase
  end

endmodule

>>> hdl/slsw_ctrl.sv
module slsw_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_restart,
  output logic              in_ready,
  input  slsw_pkg::status_t status,
  output slsw_pkg::cmd_t    cmd
);
  import slsw_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    in_ready    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start   = 1'b1;
          cmd.restart = in_restart;
          state_nxt   = ST_RUN;
        end
      end
      ST_RUN: begin
        if (status.len_zero) begin
          cmd.advance = 1'b1;
          state_nxt   = ST_IDLE;
        end else if (status.out_free) begin
          cmd.emit = 1'b1;
          if (status.last_pix) begin
            cmd.advance = 1'b1;
            state_nxt   = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

>>> hdl/slsw_dp.sv
module slsw_dp #(
  parameter int MAX_WIDTH  = 16,
  parameter int MAX_HEIGHT = 16,
  parameter int MAX_LANE   = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  slsw_pkg::cfg_t    cfg,
  input  slsw_pkg::cmd_t    cmd,
  output slsw_pkg::status_t status,
  slsw_out_if.source        out_ch
);
  import slsw_pkg::*;

  localparam logic [LANE_W-1:0] MW = LANE_W'(MAX_WIDTH);
  localparam logic [LANE_W-1:0] MH = LANE_W'(MAX_HEIGHT);
  localparam logic [LANE_W-1:0] ML = LANE_W'(MAX_LANE);

  // sweep state
  logic [DIM_W-1:0]  step_r, step_nxt;
  logic [DIM_W-1:0]  row_r, row_nxt;
  logic              left_r, left_nxt;
  // frame context
  logic [DIM_W-1:0]  fx_r, fy_r;
  logic              fleft_r;
  // pixel walk counters
  logic [DIM_W-1:0]  col_r, py_r;
  logic              odd_r;
  logic [LANE_W-1:0] k_r, len_r;
  // output register
  logic              ovalid_r;
  logic [COORD_W-1:0] ox_r, oy_r;
  logic [LEVEL_W-1:0] ored_r, ogreen_r, oblue_r, owhite_r;
  logic              olast_r;

  logic [LANE_W-1:0] w7, h7, len_c;
  logic [DIM_W-1:0]  w_eff, h_eff, x_eff, y_eff, px;
  logic [AREA_W-1:0] area;
  logic              flip;

  // clamp panel size
  always_comb begin
    w7 = LANE_W'(cfg.panel_width);
    if (w7 == '0) w7 = LANE_W'(1);
    else if (w7 > MW) w7 = MW;
    h7 = LANE_W'(cfg.panel_height);
    if (h7 == '0) h7 = LANE_W'(1);
    else if (h7 > MH) h7 = MH;
  end
  assign w_eff = w7[DIM_W-1:0];
  assign h_eff = h7[DIM_W-1:0];

  // lane length clamp
  assign area = AREA_W'(w_eff) * AREA_W'(h_eff);
  always_comb begin
    len_c = cfg.lane_pixels;
    if (AREA_W'(len_c) > area) len_c = area[LANE_W-1:0];
    if (len_c > ML) len_c = ML;
  end

  // starting position, with restart
  always_comb begin
    if (cmd.restart) begin
      x_eff = '0;
      y_eff = '0;
    end else begin
      x_eff = (step_r < w_eff) ? step_r : w_eff - DIM_W'(1);
      y_eff = (row_r < h_eff) ? row_r : h_eff - DIM_W'(1);
    end
  end

  // frame start and pixel walk
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      fx_r    <= x_eff;
      fy_r    <= y_eff;
      fleft_r <= cmd.restart ? 1'b1 : left_r;
      col_r   <= w_eff - DIM_W'(1) - x_eff;
      py_r    <= y_eff;
      odd_r   <= 1'b0;
      k_r     <= '0;
      len_r   <= len_c;
    end else if (cmd.emit) begin
      k_r <= k_r + LANE_W'(1);
      if (col_r == w_eff - DIM_W'(1)) begin
        col_r <= '0;
        odd_r <= ~odd_r;
        py_r  <= (py_r == '0) ? h_eff - DIM_W'(1) : py_r - DIM_W'(1);
      end else begin
        col_r <= col_r + DIM_W'(1);
      end
    end
  end

  // sweep advance after a frame
  always_comb begin
    step_nxt = step_r;
    row_nxt  = row_r;
    left_nxt = left_r;
    if (cmd.advance) begin
      if (fx_r == w_eff - DIM_W'(1)) begin
        step_nxt = '0;
        if (fy_r == h_eff - DIM_W'(1)) begin
          row_nxt  = '0;
          left_nxt = 1'b1;
        end else begin
          row_nxt  = fy_r + DIM_W'(1);
          left_nxt = ~fleft_r;
        end
      end else begin
        step_nxt = fx_r + DIM_W'(1);
        row_nxt  = fy_r;
        left_nxt = fleft_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
      row_r  <= '0;
      left_r <= 1'b1;
    end else begin
      step_r <= step_nxt;
      row_r  <= row_nxt;
      left_r <= left_nxt;
    end
  end

  // serpentine mirroring
  assign flip = fleft_r ? odd_r : ~odd_r;
  assign px   = flip ? (w_eff - DIM_W'(1) - col_r) : col_r;

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else if (cmd.emit) begin
      ovalid_r <= 1'b1;
    end else if (out_ch.ready) begin
      ovalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      ox_r     <= px[COORD_W-1:0];
      oy_r     <= py_r[COORD_W-1:0];
      ored_r   <= cfg.red_level;
      ogreen_r <= cfg.green_level;
      oblue_r  <= cfg.blue_level;
      owhite_r <= cfg.white_level;
      olast_r  <= (k_r == len_r - LANE_W'(1));
    end
  end

  assign out_ch.valid      = ovalid_r;
  assign out_ch.x_coord    = ox_r;
  assign out_ch.y_coord    = oy_r;
  assign out_ch.red_out    = ored_r;
  assign out_ch.green_out  = ogreen_r;
  assign out_ch.blue_out   = oblue_r;
  assign out_ch.white_out  = owhite_r;
  assign out_ch.frame_last = olast_r;

  // status to the controller
  assign status.len_zero = (len_r == '0);
  assign status.last_pix = (k_r == len_r - LANE_W'(1));
  assign status.out_free = ~ovalid_r | out_ch.ready;

endmodule

>>> hdl/serpentine_lane_sweep.sv
// lane sweep over a serpentine-wired led matrix
//
// in_ch carries one frame tick per item (restart bit). for each item the
// block emits on out_ch the lit pixels of the lane, one item per pixel,
// with the colour registers and frame_last set on the final pixel.
// a lane of zero length emits nothing but still moves the sweep on.
// configuration sits on the apb port (width, height, lane, four levels at
// byte offsets 0 to 24); write it only while the block is idle.
//
// an item is taken in idle; the controller then enters run and loads the
// output register with one pixel per cycle while the output is free, the
// pixel walk counter stepping column and row once per pixel, up to the
// last pixel of the lane; items are processed one at a time.
// a stalled receiver holds the output register and the walk waits; the
// next tick can be taken while the last pixel of a frame still waits.
// reset (rst_n low, synchronous) restores the register defaults and puts
// the sweep at row 0, column 0, moving left, with nothing pending.
module serpentine_lane_sweep #(
  parameter int MAX_WIDTH  = 16,
  parameter int MAX_HEIGHT = 16,
  parameter int MAX_LANE   = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  slsw_in_if.sink                      in_ch,
  slsw_out_if.source                   out_ch,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [slsw_pkg::ADDR_W-1:0]  paddr,
  input  logic [slsw_pkg::DATA_W-1:0]  pwdata,
  output logic [slsw_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);
  import slsw_pkg::*;

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  slsw_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  slsw_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_restart (in_ch.restart),
    .in_ready   (in_ch.ready),
    .status     (status),
    .cmd        (cmd)
  );

  slsw_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_LANE   (MAX_LANE)
  ) u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .cmd    (cmd),
    .status (status),
    .out_ch (out_ch)
  );

  // busy after taking a tick
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("tick accepted while frame in progress");

  // the final pixel ends the frame
  a_last_advances: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit && status.last_pix |-> cmd.advance)
    else $error("last pixel emitted without sweep advance");

  // after the sweep advances the block is ready again
  a_ready_after_advance: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.advance |=> in_ch.ready)
    else $error("block not idle after frame end");

  // a pixel is only loaded into a free output register
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !out_ch.valid || out_ch.ready)
    else $error("pending pixel overwritten");

endmodule
